// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/serl_pkg.sv =====
// Shared types and constants for the sequenced event ring log.
`timescale 1ns / 1ps
package serl_pkg;

  localparam int DEPTH       = 16;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int MAXC_W      = 5;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] SYNC_RESET = 32'd946684800;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_READ,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ms;
    logic [31:0] wall;
    logic [63:0] number;
    logic        known;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] event_seq;
    logic [31:0] event_ms;
    logic [31:0] event_wall;
    logic [63:0] event_number;
    logic        event_known;
    logic        last;
    logic [31:0] latest_seq;
    logic [31:0] dropped_count;
  } result_t;

endpackage

// ===== rtl/sequenced_event_ring_log.sv =====
// Top level of the sequenced event ring log: config register, RAM and sequencer.
//
// Channel  Ports                          Handshake
// input    start, busy, in_*              taken when start is high and busy is low
// result   out_strobe, out_*              valid while out_strobe is high, no back-pressure
// config   cfg_we, cfg_wdata              written when cfg_we is high
//
// A record item is written into the RAM in the cycle it is taken; records may follow each other every cycle.
// A query holds busy until its final item is shown and delivers its n items on
// consecutive cycles after the PLAN state, each read from the RAM and then registered;
// the single read port of the event RAM sets one item per cycle.
// rst_n is synchronous and clears pointers and counters; the RAM is not cleared.
// The receiver cannot stall, so nothing ever waits on the result side.
`timescale 1ns / 1ps
module sequenced_event_ring_log (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [63:0]                 in_caller_number,
  input  logic                        in_caller_present,
  input  logic [31:0]                 in_ms_time,
  input  logic [31:0]                 in_wall_time,
  input  logic [31:0]                 in_after_seq,
  input  logic [serl_pkg::MAXC_W-1:0] in_max_count,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic [31:0]                 out_event_seq,
  output logic [31:0]                 out_event_ms,
  output logic [31:0]                 out_event_wall,
  output logic [63:0]                 out_event_number,
  output logic                        out_event_known,
  output logic                        out_last,
  output logic [31:0]                 out_latest_seq,
  output logic [31:0]                 out_dropped_count,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_wdata
);

  logic [31:0]        thresh_r;
  serl_pkg::ram_req_t ram_req;
  serl_pkg::entry_t   wr_data;
  serl_pkg::entry_t   rd_data;
  serl_pkg::result_t  res;

  // Hold the sync threshold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= serl_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  serl_ram #(
    .WIDTH   (serl_pkg::ENTRY_W),
    .AW      (serl_pkg::ADDR_W),
    .ENTRIES (serl_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (wr_data),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  serl_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .req_type       (in_req_type),
    .caller_number  (in_caller_number),
    .caller_present (in_caller_present),
    .ms_time        (in_ms_time),
    .wall_time      (in_wall_time),
    .after_seq      (in_after_seq),
    .max_count      (in_max_count),
    .sync_threshold (thresh_r),
    .rd_data        (rd_data),
    .busy           (busy),
    .ram_req        (ram_req),
    .wr_data        (wr_data),
    .res_strobe     (out_strobe),
    .res            (res)
  );

  // Spread the result onto its ports
  assign out_found         = res.found;
  assign out_event_seq     = res.event_seq;
  assign out_event_ms      = res.event_ms;
  assign out_event_wall    = res.event_wall;
  assign out_event_number  = res.event_number;
  assign out_event_known   = res.event_known;
  assign out_last          = res.last;
  assign out_latest_seq    = res.latest_seq;
  assign out_dropped_count = res.dropped_count;

endmodule

// ===== rtl/serl_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module serl_ram #(
  parameter int WIDTH   = 8,
  parameter int AW      = 4,
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/serl_ctrl.sv =====
// Ring pointers, counters and the query sequencer with its result register.
`timescale 1ns / 1ps
module serl_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       req_type,
  input  logic [63:0]                caller_number,
  input  logic                       caller_present,
  input  logic [31:0]                ms_time,
  input  logic [31:0]                wall_time,
  input  logic [31:0]                after_seq,
  input  logic [serl_pkg::MAXC_W-1:0] max_count,
  input  logic [31:0]                sync_threshold,
  input  serl_pkg::entry_t           rd_data,
  output logic                       busy,
  output serl_pkg::ram_req_t         ram_req,
  output serl_pkg::entry_t           wr_data,
  output logic                       res_strobe,
  output serl_pkg::result_t          res
);

  localparam int AW    = serl_pkg::ADDR_W;
  localparam int FW    = serl_pkg::FILL_W;
  localparam int CW    = serl_pkg::CNT_W;
  localparam int AS_W  = AW + 1;
  localparam int CMP_W = (FW > CW) ? FW : CW;

  localparam logic [serl_pkg::MAXC_W-1:0] MAXC_LIMIT =
    serl_pkg::MAXC_W'(serl_pkg::MAX_RESULTS);

  serl_pkg::state_t  state_r, state_nxt;
  logic [AW-1:0]     write_pos_r, write_pos_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [31:0]       newest_r, newest_nxt;
  logic [31:0]       drop_r, drop_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic [CW-1:0]     maxc_r, maxc_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  serl_pkg::result_t out_r, out_nxt;

  logic              accept;
  logic              full;
  logic              skip_pos;
  logic              past_end;
  logic              empty;
  logic [FW-1:0]     skip_f;
  logic [FW-1:0]     avail;
  logic [CW-1:0]     n_cnt;
  logic [AW-1:0]     oldest;
  logic [AS_W-1:0]   start_sum;
  logic [AW-1:0]     start_addr;

  assign busy   = (state_r != serl_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign full   = (fill_r == FW'(serl_pkg::DEPTH));

  // Build the entry of a record item
  always_comb begin
    wr_data.seq    = newest_r + 32'd1;
    wr_data.ms     = ms_time;
    wr_data.wall   = (wall_time > sync_threshold) ? wall_time : 32'd0;
    wr_data.number = caller_present ? caller_number : 64'd0;
    wr_data.known  = caller_present;
  end

  // Plan a query: skip count, result count and first slot
  always_comb begin
    skip_pos  = (diff_r != 32'd0) && !diff_r[31];
    past_end  = skip_pos && (diff_r >= 32'(fill_r));
    empty     = (maxc_r == '0) || (fill_r == '0) || past_end;
    skip_f    = skip_pos ? diff_r[FW-1:0] : '0;
    avail     = fill_r - skip_f;
    n_cnt     = (CMP_W'(avail) < CMP_W'(maxc_r)) ? CW'(avail) : maxc_r;
    oldest    = full ? write_pos_r : '0;
    start_sum = AS_W'(oldest) + AS_W'(skip_f);
    if (start_sum >= AS_W'(serl_pkg::DEPTH)) begin
      start_addr = AW'(start_sum - AS_W'(serl_pkg::DEPTH));
    end else begin
      start_addr = AW'(start_sum);
    end
  end

  // Next state, counters and result register
  always_comb begin
    state_nxt      = state_r;
    write_pos_nxt  = write_pos_r;
    fill_nxt       = fill_r;
    newest_nxt     = newest_r;
    drop_nxt       = drop_r;
    diff_nxt       = diff_r;
    maxc_nxt       = maxc_r;
    addr_nxt       = addr_r;
    left_nxt       = left_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ram_req.we     = 1'b0;
    ram_req.waddr  = write_pos_r;
    ram_req.re     = 1'b0;
    ram_req.raddr  = addr_r;

    // Load a result returned by the RAM
    if (rd_vld_r) begin
      out_strobe_nxt        = 1'b1;
      out_nxt.found         = 1'b1;
      out_nxt.event_seq     = rd_data.seq;
      out_nxt.event_ms      = rd_data.ms;
      out_nxt.event_wall    = rd_data.wall;
      out_nxt.event_number  = rd_data.number;
      out_nxt.event_known   = rd_data.known;
      out_nxt.last          = rd_last_r;
      out_nxt.latest_seq    = newest_r;
      out_nxt.dropped_count = drop_r;
    end

    case (state_r)
      serl_pkg::ST_IDLE: begin
        if (accept && (req_type == serl_pkg::REQ_RECORD)) begin
          ram_req.we    = 1'b1;
          write_pos_nxt = (write_pos_r == AW'(serl_pkg::DEPTH - 1)) ? '0
                                                                  : write_pos_r + 1'b1;
          if (full) begin
            drop_nxt = drop_r + 32'd1;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
          newest_nxt = newest_r + 32'd1;
        end else if (accept) begin
          diff_nxt  = after_seq - drop_r;
          maxc_nxt  = (max_count > MAXC_LIMIT) ? CW'(serl_pkg::MAX_RESULTS)
                                               : CW'(max_count);
          state_nxt = serl_pkg::ST_PLAN;
        end
      end
      serl_pkg::ST_PLAN: begin
        if (empty) begin
          out_strobe_nxt        = 1'b1;
          out_nxt               = '0;
          out_nxt.last          = 1'b1;
          out_nxt.latest_seq    = newest_r;
          out_nxt.dropped_count = drop_r;
          state_nxt             = serl_pkg::ST_IDLE;
        end else begin
          addr_nxt  = start_addr;
          left_nxt  = n_cnt;
          state_nxt = serl_pkg::ST_READ;
        end
      end
      serl_pkg::ST_READ: begin
        ram_req.re  = 1'b1;
        rd_vld_nxt  = 1'b1;
        rd_last_nxt = (left_r == CW'(1));
        addr_nxt    = (addr_r == AW'(serl_pkg::DEPTH - 1)) ? '0 : addr_r + 1'b1;
        left_nxt    = left_r - 1'b1;
        if (left_r == CW'(1)) begin
          state_nxt = serl_pkg::ST_DRAIN;
        end
      end
      serl_pkg::ST_DRAIN: begin
        state_nxt = serl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = serl_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= serl_pkg::ST_IDLE;
      write_pos_r  <= '0;
      fill_r       <= '0;
      newest_r     <= '0;
      drop_r       <= '0;
      left_r       <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_pos_r  <= write_pos_nxt;
      fill_r       <= fill_nxt;
      newest_r     <= newest_nxt;
      drop_r       <= drop_nxt;
      left_r       <= left_nxt;
      rd_vld_r     <= rd_vld_nxt;
      rd_last_r    <= rd_last_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    maxc_r <= maxc_nxt;
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

  assign res_strobe = out_strobe_r;
  assign res        = out_r;

endmodule

// ===== rtl/serl_chk.sv =====
// Port-level checker for the sequenced event ring log, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module serl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_req_type,
  input logic        out_strobe,
  input logic        out_found,
  input logic        out_last,
  input logic [31:0] out_event_seq
);

  // An empty result is always the final one and carries no event
  `ASSERT_IMPL(a_empty_last, clk, rst_n, out_strobe && !out_found, out_last && (out_event_seq == 32'd0), "empty result not final or not cleared")

  // A query keeps the block busy in the next cycle
  `ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && (in_req_type == serl_pkg::REQ_QUERY), busy, "query did not raise busy")

  // Items of one query come on consecutive cycles
  `ASSERT_NEXT(a_burst, clk, rst_n, out_strobe && !out_last, out_strobe, "gap inside a query burst")

  // Busy drops only as the final item of a query is shown
  `ASSERT_IMPL(a_done, clk, rst_n, $fell(busy) && $past(rst_n), out_strobe && out_last, "busy fell without a final item")

endmodule

bind sequenced_event_ring_log serl_chk u_chk (.*);
